// ===== src/otwa_pkg.sv =====
package otwa_pkg;

  localparam int SAMPLE_W = 12;
  localparam int CFG_W    = 16;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_DEVIATION  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FULL_SCALE = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PWM_PERIOD = 2'd2;

  // shared divider: widest dividend is filtered mean times period
  localparam int DIV_DW = 28;
  localparam int DIV_VW = 16;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_VW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_DW-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== src/outlier_trimmed_window_average.sv =====
// Channel  | Transaction                        | Handshake
// ---------+------------------------------------+----------------------
// input    | sample                             | in_valid / in_stall
// output   | window_mean, filtered_mean,        | out_valid / out_stall
//          | kept_count, on_time                |
// config   | cfg_index, cfg_wdata               | cfg_we (no wait)
//
// Each sample, from acceptance to result, takes two read passes over the window RAM,
// a reciprocal multiply for the window mean and two runs of the shared radix-2
// divider, the first for the filtered mean and the second for the on time.
// An empty band or a zero full scale skips one run.
// Reset clears the write pointer and a valid bit per entry; unwritten entries read
// as zero, so there is no clearing pass. The input stalls while a sample is in
// work; a finished result waits in the output register while the next is taken.
module outlier_trimmed_window_average
  import otwa_pkg::*;
#(
  parameter int WINDOW = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [SAMPLE_W-1:0]  sample,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic [SAMPLE_W-1:0]  window_mean,
  output logic [SAMPLE_W-1:0]  filtered_mean,
  output logic [3:0]           kept_count,
  output logic [15:0]          on_time,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int AW     = $clog2(WINDOW);
  localparam int IDX_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
  localparam int KC_W   = $clog2(WINDOW + 1);
  localparam int BAND_W = 21;
  localparam int PROD_W = 28;

  // sum / WINDOW as (sum * ceil(2^RCP_SH / WINDOW)) >> RCP_SH, exact over the sum range
  localparam int RCP_SH = SUM_W + $clog2(WINDOW);
  localparam int RCP_W  = SUM_W + 1;
  localparam int MUL_W  = SUM_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP_M =
    RCP_W'(((64'd1 << RCP_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  localparam logic [7:0] PCT = 8'd100;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SUM    = 4'd1;
  localparam logic [3:0] S_MEAN   = 4'd2;
  localparam logic [3:0] S_BAND   = 4'd3;
  localparam logic [3:0] S_KEEP   = 4'd4;
  localparam logic [3:0] S_FMEAN  = 4'd5;
  localparam logic [3:0] S_SCALE  = 4'd6;
  localparam logic [3:0] S_TSTART = 4'd7;
  localparam logic [3:0] S_TDIV   = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0] state;

  logic [6:0]  dev_pct;
  logic [15:0] full_scale;
  logic [15:0] pwm_period;

  logic [AW-1:0]     wp;
  logic [WINDOW-1:0] vld;
  logic [IDX_W-1:0]  idx;
  logic              issued;
  logic              vld_rd;

  logic [SUM_W-1:0]    sum;
  logic [SAMPLE_W-1:0] mean;
  logic [BAND_W-1:0]   lo_prod;
  logic [BAND_W-1:0]   hi_prod;
  logic [SUM_W-1:0]    ksum;
  logic [KC_W-1:0]     kcnt;
  logic [SAMPLE_W-1:0] fmean;
  logic [PROD_W-1:0]   prod;
  logic [15:0]         ton;

  logic                accept;
  logic                ram_re;
  logic [SAMPLE_W-1:0] rd_data;
  logic [SAMPLE_W-1:0] entry;
  logic                pass_done;
  logic [BAND_W-1:0]   scaled;
  logic                keep;
  logic [7:0]          kcnt_ext;
  logic [MUL_W-1:0]    mean_prod;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign ram_re    = ((state == S_SUM) || (state == S_KEEP)) && (idx < IDX_W'(WINDOW));
  assign pass_done = (idx == IDX_W'(WINDOW)) && !issued;
  assign entry     = vld_rd ? rd_data : '0;

  assign mean_prod = MUL_W'(sum) * MUL_W'(RCP_M);

  // entry <= floor(x/100)  <=>  100*entry <= x ; entry >= floor(x/100) <=> 100*entry+99 >= x
  assign scaled = BAND_W'(entry) * BAND_W'(PCT);
  assign keep   = ((scaled + BAND_W'(PCT - 8'd1)) >= lo_prod) && (scaled <= hi_prod);

  assign kcnt_ext = 8'(kcnt);

  otwa_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(WINDOW)
  ) u_ram (
    .clk  (clk),
    .we   (accept),
    .waddr(wp),
    .wdata(sample),
    .re   (ram_re),
    .raddr(idx[AW-1:0]),
    .rdata(rd_data)
  );

  otwa_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  always_comb begin
    div_req = '0;
    case (state)
      S_KEEP: begin
        div_req.start    = pass_done && (kcnt != '0);
        div_req.dividend = DIV_DW'(ksum);
        div_req.divisor  = DIV_VW'(kcnt);
      end
      S_TSTART: begin
        div_req.start    = (full_scale != 16'd0);
        div_req.dividend = DIV_DW'(prod);
        div_req.divisor  = full_scale;
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_pct    <= 7'd10;
      full_scale <= 16'd3000;
      pwm_period <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEVIATION:  dev_pct    <= cfg_wdata[6:0];
        REG_FULL_SCALE: full_scale <= cfg_wdata;
        REG_PWM_PERIOD: pwm_period <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wp        <= '0;
      vld       <= '0;
      issued    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      issued <= ram_re;
      if (ram_re) begin
        vld_rd <= vld[idx[AW-1:0]];
        idx    <= idx + 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            vld[wp] <= 1'b1;
            wp      <= (wp == AW'(WINDOW - 1)) ? '0 : wp + 1'b1;
            idx     <= '0;
            sum     <= '0;
            state   <= S_SUM;
          end
        end
        S_SUM: begin
          if (issued) begin
            sum <= sum + SUM_W'(entry);
          end
          if (pass_done) begin
            state <= S_MEAN;
          end
        end
        S_MEAN: begin
          mean  <= mean_prod[RCP_SH +: SAMPLE_W];
          state <= S_BAND;
        end
        S_BAND: begin
          lo_prod <= (dev_pct >= PCT[6:0]) ? '0
                     : BAND_W'(mean) * BAND_W'(PCT - {1'b0, dev_pct});
          hi_prod <= BAND_W'(mean) * BAND_W'(PCT + {1'b0, dev_pct});
          idx     <= '0;
          ksum    <= '0;
          kcnt    <= '0;
          state   <= S_KEEP;
        end
        S_KEEP: begin
          if (issued && keep) begin
            ksum <= ksum + SUM_W'(entry);
            kcnt <= kcnt + 1'b1;
          end
          if (pass_done) begin
            if (kcnt == '0) begin
              fmean <= '0;
              state <= S_SCALE;
            end else begin
              state <= S_FMEAN;
            end
          end
        end
        S_FMEAN: begin
          if (div_rsp.done) begin
            fmean <= div_rsp.quotient[SAMPLE_W-1:0];
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          prod  <= PROD_W'(fmean) * PROD_W'(pwm_period);
          state <= S_TSTART;
        end
        S_TSTART: begin
          if (full_scale == 16'd0) begin
            ton   <= pwm_period;
            state <= S_OUT;
          end else begin
            state <= S_TDIV;
          end
        end
        S_TDIV: begin
          if (div_rsp.done) begin
            ton   <= (div_rsp.quotient > DIV_DW'(pwm_period)) ? pwm_period
                     : div_rsp.quotient[15:0];
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            window_mean   <= mean;
            filtered_mean <= fmean;
            kept_count    <= (kcnt_ext > 8'd15) ? 4'd15 : kcnt_ext[3:0];
            on_time       <= ton;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/otwa_ram.sv =====
module otwa_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/otwa_div.sv =====
module otwa_div
  import otwa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_DW + 1);

  logic [DIV_VW-1:0] rem;
  logic [DIV_DW-1:0] quo;
  logic [DIV_VW-1:0] dsr;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;

  logic [DIV_VW:0] trial;
  logic [DIV_VW:0] diff;
  logic            fits;

  // remainder stays below the divisor, so the shifted trial fits one extra bit
  assign trial = {rem, quo[DIV_DW-1]};
  assign fits  = trial >= {1'b0, dsr};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        rem  <= '0;
        quo  <= req.dividend;
        dsr  <= req.divisor;
        cnt  <= CNT_W'(DIV_DW);
      end else if (busy) begin
        rem <= fits ? diff[DIV_VW-1:0] : trial[DIV_VW-1:0];
        quo <= {quo[DIV_DW-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule
